// File: hw/rtl/wet_pkg.sv
// Shared types and constants for the weighted edge table.
package wet_pkg;

   localparam int unsigned WET_MAX_EDGES = 256;
   localparam int unsigned WET_MAX_NODES = 128;
   localparam int unsigned ID_W          = 32;
   localparam int unsigned WEIGHT_W      = 32;

   typedef enum logic [2:0] {
      REQ_INCREASE = 3'd0,
      REQ_DECREASE = 3'd1,
      REQ_REMOVE   = 3'd2,
      REQ_GET      = 3'd3,
      REQ_SUPPRESS = 3'd4
   } wet_req_code_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_SAME_NODE = 3'd1,
      STAT_NO_EDGE   = 3'd2,
      STAT_NO_NODE   = 3'd3,
      STAT_FULL      = 3'd4
   } wet_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_NODE_B,
      ST_RESP
   } wet_state_type;

   typedef struct packed {
      logic [ID_W-1:0]     low_id;
      logic [ID_W-1:0]     high_id;
      logic [WEIGHT_W-1:0] weight;
   } wet_edge_type;

   typedef struct packed {
      logic pair;    // entry holds the requested id pair
      logic touch;   // entry has the first id at either end
      logic node_a;  // node entry equals the first id
      logic node_b;  // node entry equals the second id
   } wet_hit_type;

endpackage

// File: hw/rtl/wet_chan_if.sv
// Valid/ready channel interfaces for request and response beats.
interface wet_req_if
   import wet_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [2:0]          req_type;
   logic [ID_W-1:0]     first_node;
   logic [ID_W-1:0]     second_node;
   logic [WEIGHT_W-1:0] amount;

   modport source (output valid, req_type, first_node, second_node, amount, input ready);
   modport sink   (input valid, req_type, first_node, second_node, amount, output ready);
endinterface

interface wet_rsp_if
   import wet_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [2:0]          status;
   logic [WEIGHT_W-1:0] weight_out;
   logic                edge_present;

   modport source (output valid, status, weight_out, edge_present, input ready);
   modport sink   (input valid, status, weight_out, edge_present, output ready);
endinterface

// File: hw/rtl/wet_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wet_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/wet_cmp.sv
// Shared compare unit: matches one edge entry and one node entry against the request keys.
module wet_cmp
   import wet_pkg::*;
(
   input  wet_edge_type    edge_entry,
   input  logic [ID_W-1:0] node_val,
   input  logic [ID_W-1:0] key_lo,
   input  logic [ID_W-1:0] key_hi,
   input  logic [ID_W-1:0] key_a,
   input  logic [ID_W-1:0] key_b,
   output wet_hit_type     hit
);

   // Compare the ordered pair, the touched end and both node ids
   always_comb begin
      hit.pair   = (edge_entry.low_id == key_lo) && (edge_entry.high_id == key_hi);
      hit.touch  = (edge_entry.low_id == key_a) || (edge_entry.high_id == key_a);
      hit.node_a = (node_val == key_a);
      hit.node_b = (node_val == key_b);
   end

endmodule

// File: hw/rtl/weighted_edge_table_core.sv
// Weighted edge table top level: sequencer, tracking registers, edge and node stores.
// The response goes valid after one linear pass over the edge RAM and the node RAM, one entry
// of each per cycle through their single read ports, followed by an update state (and a
// second node write state when an increase adds two new nodes), and stays valid until taken.
// Suppress clears every edge that touches the node, and the node entry itself, during that
// same pass. The input is ready only while the block is idle, which it becomes the cycle
// after the response beat, so the block takes no new request until the last response is taken.
module weighted_edge_table_core
   import wet_pkg::*;
#(
   parameter int unsigned MAX_EDGES = WET_MAX_EDGES,
   parameter int unsigned MAX_NODES = WET_MAX_NODES
) (
   input logic        clock,
   input logic        reset,
   wet_req_if.sink    req_bus,
   wet_rsp_if.source  rsp_bus
);

   localparam int unsigned EIW      = $clog2(MAX_EDGES);
   localparam int unsigned NIW      = $clog2(MAX_NODES);
   localparam int unsigned SCAN_LEN = (MAX_EDGES > MAX_NODES) ? MAX_EDGES : MAX_NODES;
   localparam int unsigned SW       = $clog2(SCAN_LEN + 1);
   localparam int unsigned EDGE_W   = $bits(wet_edge_type);
   localparam logic [SW-1:0] SCAN_END = SW'(SCAN_LEN);
   localparam logic [SW-1:0] LAST_IDX = SW'(SCAN_LEN - 1);
   localparam logic [SW-1:0] EDGE_END = SW'(MAX_EDGES);
   localparam logic [SW-1:0] NODE_END = SW'(MAX_NODES);

   wet_state_type state_ff, state_in;

   // Request fields
   wet_req_code_type    code_ff;
   logic [ID_W-1:0]     a_ff, b_ff, lo_ff, hi_ff;
   logic [WEIGHT_W-1:0] amt_ff;

   // Scan control
   logic [SW-1:0] cnt_ff;
   logic [SW-1:0] cmp_idx_ff;
   logic          cmp_v_ff;
   logic          e_used_rd_ff, n_used_rd_ff;

   // Scan results
   logic                edge_hit_ff;
   logic [EIW-1:0]      edge_hit_idx_ff;
   logic [WEIGHT_W-1:0] edge_w_ff;
   logic                edge_free_ff;
   logic [EIW-1:0]      edge_free_idx_ff;
   logic                na_ff, nb_ff;
   logic                nfree0_ff, nfree1_ff;
   logic [NIW-1:0]      nfree0_idx_ff, nfree1_idx_ff;

   // Used bits
   logic [MAX_EDGES-1:0] edge_used_ff;
   logic [MAX_NODES-1:0] node_used_ff;

   // Response register
   wet_status_type      status_ff;
   logic [WEIGHT_W-1:0] wout_ff;
   logic                present_ff;

   // Stores
   logic                edge_wr_en;
   logic [EIW-1:0]      edge_wr_addr;
   wet_edge_type        edge_wr_data;
   logic [EDGE_W-1:0]   edge_rd_raw;
   wet_edge_type        edge_rd;
   logic                node_wr_en;
   logic [NIW-1:0]      node_wr_addr;
   logic [ID_W-1:0]     node_wr_data;
   logic [ID_W-1:0]     node_rd;

   wet_hit_type hit;

   logic accept, scan_step, scan_done;
   logic edge_ok, node_ok, e_used, n_used;
   logic scan_clr_edge, scan_clr_node;

   // Update decision
   wet_status_type      dec_status;
   logic [WEIGHT_W-1:0] dec_wout;
   logic                dec_present;
   logic                dec_edge_wr, dec_set_used, dec_clr_used, dec_node_wr, dec_two_nodes;
   logic [EIW-1:0]      dec_edge_addr;
   logic [WEIGHT_W-1:0] dec_weight;
   logic                need_a, need_b, same, full;
   logic [WEIGHT_W:0]   sum_wide;

   wet_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_addr (cnt_ff[EIW-1:0]),
      .rd_data (edge_rd_raw)
   );

   wet_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_addr (cnt_ff[NIW-1:0]),
      .rd_data (node_rd)
   );

   assign edge_rd = wet_edge_type'(edge_rd_raw);

   wet_cmp u_cmp (
      .edge_entry (edge_rd),
      .node_val   (node_rd),
      .key_lo     (lo_ff),
      .key_hi     (hi_ff),
      .key_a      (a_ff),
      .key_b      (b_ff),
      .hit        (hit)
   );

   // Handshake and scan qualifiers
   always_comb begin
      accept        = req_bus.valid && req_bus.ready;
      scan_step     = (state_ff == ST_SCAN) && (cnt_ff != SCAN_END);
      scan_done     = cmp_v_ff && (cmp_idx_ff == LAST_IDX);
      edge_ok       = cmp_v_ff && (cmp_idx_ff < EDGE_END);
      node_ok       = cmp_v_ff && (cmp_idx_ff < NODE_END);
      e_used        = edge_ok && e_used_rd_ff;
      n_used        = node_ok && n_used_rd_ff;
      scan_clr_edge = (code_ff == REQ_SUPPRESS) && e_used && hit.touch;
      scan_clr_node = (code_ff == REQ_SUPPRESS) && n_used && hit.node_a;
   end

   // Decide the update from what the scan found
   always_comb begin
      need_a   = !na_ff;
      need_b   = !nb_ff;
      same     = (a_ff == b_ff);
      sum_wide = {1'b0, edge_w_ff} + {1'b0, amt_ff};
      full     = !edge_free_ff || ((need_a || need_b) && !nfree0_ff)
                 || (need_a && need_b && !nfree1_ff);

      dec_status    = STAT_OK;
      dec_wout      = '0;
      dec_present   = 1'b0;
      dec_edge_wr   = 1'b0;
      dec_edge_addr = edge_hit_idx_ff;
      dec_weight    = amt_ff;
      dec_set_used  = 1'b0;
      dec_clr_used  = 1'b0;
      dec_node_wr   = 1'b0;
      dec_two_nodes = 1'b0;

      case (code_ff)
         REQ_INCREASE: begin
            if (same) begin
               dec_status = STAT_SAME_NODE;
            end else if (edge_hit_ff) begin
               // Accumulate, saturating on carry
               dec_edge_wr = 1'b1;
               dec_weight  = sum_wide[WEIGHT_W] ? '1 : sum_wide[WEIGHT_W-1:0];
               dec_present = 1'b1;
            end else if (full) begin
               dec_status = STAT_FULL;
            end else begin
               dec_edge_wr   = 1'b1;
               dec_edge_addr = edge_free_idx_ff;
               dec_set_used  = 1'b1;
               dec_present   = 1'b1;
               dec_node_wr   = need_a || need_b;
               dec_two_nodes = need_a && need_b;
            end
         end
         REQ_DECREASE: begin
            if (same) begin
               dec_status = STAT_SAME_NODE;
            end else if (!edge_hit_ff) begin
               dec_status = STAT_NO_EDGE;
            end else if (edge_w_ff > amt_ff) begin
               dec_edge_wr = 1'b1;
               dec_weight  = edge_w_ff - amt_ff;
               dec_present = 1'b1;
            end else begin
               dec_clr_used = 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (!edge_hit_ff) begin
               dec_status = STAT_NO_EDGE;
            end else begin
               dec_clr_used = 1'b1;
            end
         end
         REQ_GET: begin
            if (!edge_hit_ff) begin
               dec_status = STAT_NO_EDGE;
            end else begin
               dec_wout    = edge_w_ff;
               dec_present = 1'b1;
            end
         end
         REQ_SUPPRESS: begin
            if (!na_ff) begin
               dec_status = STAT_NO_NODE;
            end
         end
         default: begin
            dec_status = STAT_OK;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = dec_two_nodes ? ST_NODE_B : ST_RESP;
         end
         ST_NODE_B: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and store write ports
   always_comb begin
      req_bus.ready       = (state_ff == ST_IDLE);
      rsp_bus.valid       = (state_ff == ST_RESP);
      edge_wr_en          = (state_ff == ST_APPLY) && dec_edge_wr;
      edge_wr_addr        = dec_edge_addr;
      edge_wr_data.low_id = lo_ff;
      edge_wr_data.high_id = hi_ff;
      edge_wr_data.weight = dec_weight;
      node_wr_en          = ((state_ff == ST_APPLY) && dec_node_wr) || (state_ff == ST_NODE_B);
      node_wr_addr        = (state_ff == ST_NODE_B) ? nfree1_idx_ff : nfree0_idx_ff;
      node_wr_data        = ((state_ff == ST_APPLY) && need_a) ? a_ff : b_ff;
   end

   assign rsp_bus.status       = status_ff;
   assign rsp_bus.weight_out   = wout_ff;
   assign rsp_bus.edge_present = present_ff;

   // Control state and used bits
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_v_ff     <= 1'b0;
         edge_used_ff <= '0;
         node_used_ff <= '0;
      end else begin
         state_ff <= state_in;
         cmp_v_ff <= scan_step;
         if (scan_clr_edge) begin
            edge_used_ff[cmp_idx_ff[EIW-1:0]] <= 1'b0;
         end
         if (scan_clr_node) begin
            node_used_ff[cmp_idx_ff[NIW-1:0]] <= 1'b0;
         end
         if ((state_ff == ST_APPLY) && dec_set_used) begin
            edge_used_ff[dec_edge_addr] <= 1'b1;
         end
         if ((state_ff == ST_APPLY) && dec_clr_used) begin
            edge_used_ff[dec_edge_addr] <= 1'b0;
         end
         if (node_wr_en) begin
            node_used_ff[node_wr_addr] <= 1'b1;
         end
      end
   end

   // Request capture, scan counter, scan trackers and response
   always_ff @(posedge clock) begin
      cmp_idx_ff <= cnt_ff;
      // Read the used bits alongside the store entries
      e_used_rd_ff <= edge_used_ff[cnt_ff[EIW-1:0]];
      n_used_rd_ff <= node_used_ff[cnt_ff[NIW-1:0]];
      if (accept) begin
         code_ff      <= wet_req_code_type'(req_bus.req_type);
         a_ff         <= req_bus.first_node;
         b_ff         <= req_bus.second_node;
         amt_ff       <= req_bus.amount;
         lo_ff        <= (req_bus.first_node < req_bus.second_node) ?
                         req_bus.first_node : req_bus.second_node;
         hi_ff        <= (req_bus.first_node < req_bus.second_node) ?
                         req_bus.second_node : req_bus.first_node;
         cnt_ff       <= '0;
         edge_hit_ff  <= 1'b0;
         edge_free_ff <= 1'b0;
         na_ff        <= 1'b0;
         nb_ff        <= 1'b0;
         nfree0_ff    <= 1'b0;
         nfree1_ff    <= 1'b0;
      end else begin
         if (scan_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         // Keep the first matching edge and the first free edge slot
         if (e_used && hit.pair && !edge_hit_ff) begin
            edge_hit_ff     <= 1'b1;
            edge_hit_idx_ff <= cmp_idx_ff[EIW-1:0];
            edge_w_ff       <= edge_rd.weight;
         end
         if (edge_ok && !e_used && !edge_free_ff) begin
            edge_free_ff     <= 1'b1;
            edge_free_idx_ff <= cmp_idx_ff[EIW-1:0];
         end
         // Note known nodes and the first two free node slots
         if (n_used && hit.node_a) begin
            na_ff <= 1'b1;
         end
         if (n_used && hit.node_b) begin
            nb_ff <= 1'b1;
         end
         if (node_ok && !n_used) begin
            if (!nfree0_ff) begin
               nfree0_ff     <= 1'b1;
               nfree0_idx_ff <= cmp_idx_ff[NIW-1:0];
            end else if (!nfree1_ff) begin
               nfree1_ff     <= 1'b1;
               nfree1_idx_ff <= cmp_idx_ff[NIW-1:0];
            end
         end
      end
      if (state_ff == ST_APPLY) begin
         status_ff  <= dec_status;
         wout_ff    <= dec_wout;
         present_ff <= dec_present;
      end
   end

   // Checks
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_SCAN))
      else $error("accepted beat did not start a scan");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("request taken while a response is pending");

   a_full_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (status_ff == STAT_FULL)) |-> !present_ff)
      else $error("table full reported with edge present");

   a_weight_get: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (wout_ff != '0)) |-> ((code_ff == REQ_GET) && (status_ff == STAT_OK)))
      else $error("weight returned for a request other than a successful get");

   a_node_b: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NODE_B) |-> (($past(state_ff) == ST_APPLY) && (code_ff == REQ_INCREASE)))
      else $error("second node write outside an increase");

endmodule
